// File: sv/wbsm_pkg.sv
// wbsm_pkg: shared types and constants of the wildcard byte signature matcher
// no dependencies; imported by the interfaces, the cells, the aligner and the top level

package wbsm_pkg;

   localparam int DATA_W  = 8;
   localparam int IDX_W   = 6;
   localparam int LEN_W   = 7;
   localparam int OFF_W   = 32;
   localparam int CSR_A_W = 1;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_SCAN = 1'b1;

   localparam logic [CSR_A_W-1:0] CSR_SIG_LEN  = 1'd0;
   localparam logic [CSR_A_W-1:0] CSR_ANCHORED = 1'd1;

   localparam logic [OFF_W-1:0] COUNT_MAX = '1;

   typedef logic [DATA_W-1:0] byte_type;

   typedef struct packed {
      logic shift_en;
      logic wr_en;
   } cell_ctl_type;

endpackage

// File: sv/wbsm_req_if.sv
// wbsm_req_if: request channel carrying load and scan transactions
// depends on wbsm_pkg

interface wbsm_req_if;
   import wbsm_pkg::*;

   logic             valid;
   logic             ready;
   logic             action;
   logic [IDX_W-1:0] sig_index;
   byte_type         sig_value;
   byte_type         sig_mask;
   byte_type         data_byte;
   logic             last;

   modport source (output valid, action, sig_index, sig_value, sig_mask, data_byte, last,
                   input ready);
   modport sink   (input valid, action, sig_index, sig_value, sig_mask, data_byte, last,
                   output ready);
endinterface

// File: sv/wbsm_rsp_if.sv
// wbsm_rsp_if: response channel carrying the match verdict of one stream
// depends on wbsm_pkg

interface wbsm_rsp_if;
   import wbsm_pkg::*;

   logic             valid;
   logic             ready;
   logic             found;
   logic [OFF_W-1:0] match_offset;

   modport source (output valid, found, match_offset, input ready);
   modport sink   (input valid, found, match_offset, output ready);
endinterface

// File: sv/wbsm_cell.sv
// wbsm_cell: one window position and one signature byte with its bitwise masked compare
// depends on wbsm_pkg

module wbsm_cell (
   input  logic                  clock,
   input  wbsm_pkg::cell_ctl_type ctl,
   input  wbsm_pkg::byte_type    shift_in,
   output wbsm_pkg::byte_type    shift_out,
   input  wbsm_pkg::byte_type    wr_value,
   input  wbsm_pkg::byte_type    wr_mask,
   input  wbsm_pkg::byte_type    aligned,
   input  logic                  active,
   output logic                  hit
);
   import wbsm_pkg::*;

   byte_type win_ff;
   byte_type value_ff;
   byte_type mask_ff;

   always_ff @(posedge clock) begin
      if (ctl.shift_en) begin
         win_ff <= shift_in;
      end
      if (ctl.wr_en) begin
         value_ff <= wr_value;
         mask_ff  <= wr_mask;
      end
   end

   assign shift_out = win_ff;
   assign hit       = !active || ((mask_ff | aligned) == value_ff);

endmodule

// File: sv/wbsm_align.sv
// wbsm_align: log-depth shifter that lines the newest window bytes up with the cells
// depends on wbsm_pkg

module wbsm_align #(
   parameter int NUM_CELLS = 64,
   parameter int SH_W      = 6
) (
   input  wbsm_pkg::byte_type win     [NUM_CELLS],
   input  logic [SH_W-1:0]    shift,
   output wbsm_pkg::byte_type aligned [NUM_CELLS]
);
   import wbsm_pkg::*;

   byte_type stg [SH_W+1][NUM_CELLS];

   always_comb begin
      for (int j = 0; j < NUM_CELLS; j++) begin
         stg[0][j] = win[j];
      end
      for (int s = 0; s < SH_W; s++) begin
         for (int j = 0; j < NUM_CELLS; j++) begin
            if (shift[s] && (j + (1 << s) < NUM_CELLS)) begin
               stg[s+1][j] = stg[s][j + (1 << s)];
            end else if (shift[s]) begin
               stg[s+1][j] = '0;
            end else begin
               stg[s+1][j] = stg[s][j];
            end
         end
      end
      for (int j = 0; j < NUM_CELLS; j++) begin
         aligned[j] = stg[SH_W][j];
      end
   end

endmodule

// File: sv/wildcard_byte_signature_matcher.sv
// Wildcard byte signature matcher. Load transactions write one signature byte
// (value and bitwise wildcard mask) into the cell of that index; scan transactions
// shift one data byte into a row of MAX_SIGNATURE cells, each holding one window
// byte and one signature byte. A scan transaction is taken every cycle while the
// input does not stall; its match check runs in the following cycle over all cells
// at once, with a log-depth shifter lining the newest bytes up with the signature.
// The verdict of a stream is registered in the check stage, then in the response
// register. Input stalls only while a second stream end reaches the check stage
// and the previous verdict has not been taken. No clearing pass is needed after reset.
// depends on wbsm_pkg, wbsm_req_if, wbsm_rsp_if, wbsm_cell, wbsm_align

module wildcard_byte_signature_matcher #(
   parameter int MAX_SIGNATURE = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   wbsm_req_if.sink                     req,
   wbsm_rsp_if.source                   rsp,
   input  logic                         csr_wen,
   input  logic [wbsm_pkg::CSR_A_W-1:0] csr_index,
   input  logic [wbsm_pkg::LEN_W-1:0]   csr_wdata
);
   import wbsm_pkg::*;

   localparam int SH_W = (MAX_SIGNATURE > 1) ? $clog2(MAX_SIGNATURE) : 1;
   localparam int LU_W = $clog2(MAX_SIGNATURE + 1);

   // configuration
   logic [LEN_W-1:0] sig_len_ff;
   logic             anchored_ff;

   // stream state
   logic [OFF_W-1:0] bytes_seen_ff, bytes_seen_in;
   logic             match_seen_ff, match_seen_in;
   logic [OFF_W-1:0] first_off_ff, first_off_in;

   // check stage
   logic             s2_valid_ff, s2_valid_in;
   logic             s2_last_ff, s2_last_in;
   logic [OFF_W-1:0] s2_count_ff, s2_count_in;

   // response register
   logic             out_valid_ff, out_valid_in;
   logic             out_found_ff, out_found_in;
   logic [OFF_W-1:0] out_off_ff, out_off_in;

   logic             stall;
   logic             fire;
   logic             scan_fire;
   logic             load_fire;
   logic             s2_done;
   logic [OFF_W-1:0] count_inc;
   logic [LEN_W-1:0] len_eff;
   logic [LU_W-1:0]  used_len;
   logic [SH_W-1:0]  shift_amt;
   logic [OFF_W-1:0] start;
   logic             all_hit;
   logic             new_hit;
   logic             match_next;
   logic [OFF_W-1:0] off_next;

   byte_type         win      [MAX_SIGNATURE];
   byte_type         aligned  [MAX_SIGNATURE];
   byte_type         chain_in [MAX_SIGNATURE];
   logic [MAX_SIGNATURE-1:0] hits;
   cell_ctl_type     cell_ctl [MAX_SIGNATURE];

   assign stall     = s2_valid_ff && s2_last_ff && out_valid_ff && !rsp.ready;
   assign req.ready = !stall;
   assign fire      = req.valid && req.ready;
   assign scan_fire = fire && (req.action == ACT_SCAN);
   assign load_fire = fire && (req.action == ACT_LOAD);
   assign s2_done   = s2_valid_ff && !stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_len_ff  <= LEN_W'(1);
         anchored_ff <= 1'b0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_SIG_LEN:  sig_len_ff  <= csr_wdata;
            CSR_ANCHORED: anchored_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // effective signature length
   always_comb begin
      len_eff = (sig_len_ff == '0) ? LEN_W'(1) : sig_len_ff;
      if (32'(len_eff) > MAX_SIGNATURE) begin
         used_len = LU_W'(MAX_SIGNATURE);
      end else begin
         used_len = LU_W'(len_eff);
      end
      shift_amt = SH_W'(MAX_SIGNATURE - int'(used_len));
   end

   // cell row, newest byte enters at the top cell
   for (genvar j = 0; j < MAX_SIGNATURE; j++) begin : g_cell
      if (j == MAX_SIGNATURE - 1) begin : g_top
         assign chain_in[j] = req.data_byte;
      end else begin : g_mid
         assign chain_in[j] = win[j+1];
      end

      assign cell_ctl[j].shift_en = scan_fire;
      assign cell_ctl[j].wr_en    = load_fire && (32'(req.sig_index) == j);

      wbsm_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl[j]),
         .shift_in  (chain_in[j]),
         .shift_out (win[j]),
         .wr_value  (req.sig_value),
         .wr_mask   (req.sig_mask),
         .aligned   (aligned[j]),
         .active    (32'(used_len) > j),
         .hit       (hits[j])
      );
   end

   wbsm_align #(
      .NUM_CELLS (MAX_SIGNATURE),
      .SH_W      (SH_W)
   ) u_align (
      .win     (win),
      .shift   (shift_amt),
      .aligned (aligned)
   );

   assign all_hit = &hits;

   // acceptance side
   always_comb begin
      count_inc     = (bytes_seen_ff == COUNT_MAX) ? bytes_seen_ff : bytes_seen_ff + 1'b1;
      bytes_seen_in = bytes_seen_ff;
      if (scan_fire) begin
         bytes_seen_in = req.last ? '0 : count_inc;
      end
      s2_valid_in = s2_valid_ff;
      s2_last_in  = s2_last_ff;
      s2_count_in = s2_count_ff;
      if (!stall) begin
         s2_valid_in = scan_fire;
         s2_last_in  = req.last;
         s2_count_in = count_inc;
      end
   end

   // check stage
   always_comb begin
      start      = s2_count_ff - OFF_W'(used_len);
      new_hit    = !match_seen_ff && (s2_count_ff >= OFF_W'(used_len))
                   && (!anchored_ff || (start == '0)) && all_hit;
      match_next = match_seen_ff || new_hit;
      off_next   = new_hit ? start : first_off_ff;

      match_seen_in = match_seen_ff;
      first_off_in  = first_off_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_found_in  = out_found_ff;
      out_off_in    = out_off_ff;
      if (s2_done) begin
         match_seen_in = match_next;
         first_off_in  = off_next;
         if (s2_last_ff) begin
            match_seen_in = 1'b0;
            first_off_in  = '0;
            out_valid_in  = 1'b1;
            out_found_in  = match_next;
            out_off_in    = match_next ? off_next : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         match_seen_ff <= 1'b0;
         first_off_ff  <= '0;
         s2_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
         match_seen_ff <= match_seen_in;
         first_off_ff  <= first_off_in;
         s2_valid_ff   <= s2_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_last_ff   <= s2_last_in;
      s2_count_ff  <= s2_count_in;
      out_found_ff <= out_found_in;
      out_off_ff   <= out_off_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.found        = out_found_ff;
   assign rsp.match_offset = out_off_ff;

   a_verdict_out: assert property (@(posedge clock) disable iff (reset)
      s2_done && s2_last_ff |=> rsp.valid)
      else $error("stream end did not produce a verdict");

   a_match_cleared: assert property (@(posedge clock) disable iff (reset)
      s2_done && s2_last_ff |=> !match_seen_ff && (first_off_ff == '0))
      else $error("match state survived the end of a stream");

   a_count_cleared: assert property (@(posedge clock) disable iff (reset)
      scan_fire && req.last |=> bytes_seen_ff == '0)
      else $error("byte count not cleared after last byte");

   a_no_offset_without_match: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.found |-> rsp.match_offset == '0)
      else $error("offset reported without a match");

   a_stall_holds_check: assert property (@(posedge clock) disable iff (reset)
      stall |=> s2_valid_ff && s2_last_ff)
      else $error("check stage lost a pending stream end");

endmodule
